// ----- hdl/tpgs_pkg.sv -----
// ----------------------------------------------------------------------------
// tpgs_pkg
// Shared types, codes and fixed widths for the toroidal probe grid scroller.
// ----------------------------------------------------------------------------
package tpgs_pkg;

  localparam int LOGICAL_BITS  = 8;
  localparam int INDEX_BITS    = 24;
  localparam int AXES          = 3;
  localparam int APB_ADDR_BITS = 4;
  localparam int APB_DATA_BITS = 32;
  localparam int RESET_COUNT   = 16;

  typedef enum logic [1:0] {
    REG_COUNT_X = 2'd0,
    REG_COUNT_Y = 2'd1,
    REG_COUNT_Z = 2'd2
  } reg_index_t;

  typedef enum logic {
    FUNC_SCROLL = 1'b0,
    FUNC_QUERY  = 1'b1
  } func_t;

  typedef enum logic [2:0] {
    SEQ_IDLE,
    SEQ_DELTA,
    SEQ_START,
    SEQ_WAIT,
    SEQ_MUL_HI,
    SEQ_MUL_MID,
    SEQ_SUM,
    SEQ_DONE
  } seq_state_t;

  typedef enum logic [1:0] {
    MOD_IDLE,
    MOD_RUN,
    MOD_FIX
  } mod_state_t;

  typedef struct packed {
    logic start;
    logic short_op;
    logic neg;
  } mod_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mod_stat_t;

  function automatic int max2(input int a, input int b);
    return (a > b) ? a : b;
  endfunction

endpackage

// ----- hdl/tpgs_if.sv -----
// ----------------------------------------------------------------------------
// tpgs_if
// Command and response channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface tpgs_cmd_if
  import tpgs_pkg::*;
#(
  parameter int CELL_BITS = 24
) ();
  logic                        valid;
  logic                        ready;
  logic                        func;
  logic signed [CELL_BITS-1:0] target_cell_x;
  logic signed [CELL_BITS-1:0] target_cell_y;
  logic signed [CELL_BITS-1:0] target_cell_z;
  logic [LOGICAL_BITS-1:0]     logical_x;
  logic [LOGICAL_BITS-1:0]     logical_y;
  logic [LOGICAL_BITS-1:0]     logical_z;

  modport source (
    output valid, func, target_cell_x, target_cell_y, target_cell_z,
           logical_x, logical_y, logical_z,
    input  ready
  );

  modport sink (
    input  valid, func, target_cell_x, target_cell_y, target_cell_z,
           logical_x, logical_y, logical_z,
    output ready
  );
endinterface

interface tpgs_rsp_if
  import tpgs_pkg::*;
#(
  parameter int COUNT_BITS = 8
) ();
  logic                  valid;
  logic                  ready;
  logic [COUNT_BITS-1:0] origin_x;
  logic [COUNT_BITS-1:0] origin_y;
  logic [COUNT_BITS-1:0] origin_z;
  logic                  moved;
  logic                  full_invalid;
  logic [COUNT_BITS-1:0] phys_x;
  logic [COUNT_BITS-1:0] phys_y;
  logic [COUNT_BITS-1:0] phys_z;
  logic [INDEX_BITS-1:0] phys_index;
  logic                  newly_exposed;

  modport source (
    output valid, origin_x, origin_y, origin_z, moved, full_invalid,
           phys_x, phys_y, phys_z, phys_index, newly_exposed,
    input  ready
  );

  modport sink (
    input  valid, origin_x, origin_y, origin_z, moved, full_invalid,
           phys_x, phys_y, phys_z, phys_index, newly_exposed,
    output ready
  );
endinterface

// ----- hdl/toroidal_probe_grid_scroller_core.sv -----
// ----------------------------------------------------------------------------
// toroidal_probe_grid_scroller_core
// Ring-buffer probe grid scroller: scroll plans and wrapped coordinate queries.
// ----------------------------------------------------------------------------
// One item is handled at a time and cmd.ready is high only while the block is
// idle; a finished result sits in an output register, so the next command can
// be taken while that response beat waits. Per axis, all modulo work runs
// through one shared bit-serial modulo unit, one bit a cycle. A query runs a
// QW-bit modulo pass per axis, with QW = max(COUNT_BITS,8)+1, and then the
// multiplier states SEQ_MUL_HI and SEQ_MUL_MID and the final sum of the linear
// index in SEQ_SUM. A scroll that changes the camera cell runs a DW-bit pass
// per axis, with DW = max(max(COUNT_BITS+1,CELL_BITS+1)+1, QW); an unchanged
// scroll only steps through SEQ_DELTA and runs no modulo pass. An axis with a
// zero count skips its modulo pass, which shortens both. Counts are written over
// APB at 0x0, 0x4 and 0x8 and must only be changed while the block is idle.
module toroidal_probe_grid_scroller_core
  import tpgs_pkg::*;
#(
  parameter int COUNT_BITS = 8,
  parameter int CELL_BITS  = 24
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [APB_ADDR_BITS-1:0] paddr,
  input  logic [APB_DATA_BITS-1:0] pwdata,
  output logic [APB_DATA_BITS-1:0] prdata,
  output logic                     pready,
  tpgs_cmd_if.sink                 cmd,
  tpgs_rsp_if.source               rsp
);

  localparam int QW = max2(COUNT_BITS, LOGICAL_BITS) + 1;
  localparam int SW = max2(COUNT_BITS + 1, CELL_BITS + 1) + 1;
  localparam int DW = max2(SW, QW);
  localparam int MW = INDEX_BITS + COUNT_BITS;
  localparam logic [1:0] LAST_AXIS = 2'(AXES - 1);

  logic [AXES-1:0][COUNT_BITS-1:0] counts;

  seq_state_t state;
  seq_state_t state_next;
  logic [1:0] axis;
  func_t      func_r;

  logic [COUNT_BITS-1:0]   ring_origin [AXES];
  logic [CELL_BITS-1:0]    camera_cell [AXES];
  logic [CELL_BITS:0]      cell_delta  [AXES];
  logic                    plan_changed;
  logic                    plan_full_invalid;

  logic [CELL_BITS-1:0]    tgt  [AXES];
  logic [LOGICAL_BITS-1:0] lg   [AXES];
  logic [COUNT_BITS-1:0]   phys [AXES];
  logic [INDEX_BITS-1:0]   prod;
  logic [INDEX_BITS-1:0]   index_r;
  logic                    nexp;

  logic                    rsp_valid;
  logic [COUNT_BITS-1:0]   rsp_origin [AXES];
  logic                    rsp_moved;
  logic                    rsp_full;
  logic [COUNT_BITS-1:0]   rsp_phys [AXES];
  logic [INDEX_BITS-1:0]   rsp_index;
  logic                    rsp_nexp;

  logic                    accept;
  logic                    changed_in;
  logic                    out_free;
  logic                    is_last;
  logic                    is_scroll;
  logic [COUNT_BITS-1:0]   cnt_cur;
  logic                    cnt_zero;
  logic [CELL_BITS:0]      d_new;
  logic [CELL_BITS:0]      d_cur;
  logic                    d_neg;
  logic                    d_pos;
  logic [CELL_BITS:0]      d_mag;
  logic [DW-1:0]           mag_w;
  logic [DW-1:0]           cnt_w;
  logic [DW-1:0]           lg_w;
  logic                    exp_axis;
  logic [DW-1:0]           s_sum;
  logic                    s_neg;
  logic [DW-1:0]           s_mag;
  logic [DW-1:0]           q_sum;

  mod_ctrl_t               mod_ctrl;
  mod_stat_t               mod_stat;
  logic [DW-1:0]           mod_dividend;
  logic [COUNT_BITS-1:0]   mod_result;

  logic                    axis_adv;
  logic [INDEX_BITS-1:0]   mul_a;
  logic [COUNT_BITS-1:0]   mul_b;
  logic [MW-1:0]           mul_full;

  tpgs_regs #(
    .COUNT_BITS(COUNT_BITS)
  ) u_regs (
    .clk    (clk),
    .rst    (rst),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .counts (counts)
  );

  tpgs_mod #(
    .COUNT_BITS(COUNT_BITS),
    .DW        (DW),
    .QW        (QW)
  ) u_mod (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (mod_ctrl),
    .dividend(mod_dividend),
    .modulus (cnt_cur),
    .result  (mod_result),
    .stat    (mod_stat)
  );

  assign accept     = cmd.valid && cmd.ready;
  assign changed_in = (cmd.target_cell_x != camera_cell[0]) ||
                      (cmd.target_cell_y != camera_cell[1]) ||
                      (cmd.target_cell_z != camera_cell[2]);
  assign out_free   = !rsp_valid || rsp.ready;
  assign is_last    = (axis == LAST_AXIS);
  assign is_scroll  = (func_r == FUNC_SCROLL);
  assign cnt_cur    = counts[axis];
  assign cnt_zero   = (cnt_cur == '0);

  // per-axis delta and exposure terms
  assign d_new    = {tgt[axis][CELL_BITS-1], tgt[axis]} -
                    {camera_cell[axis][CELL_BITS-1], camera_cell[axis]};
  assign d_cur    = cell_delta[axis];
  assign d_neg    = d_cur[CELL_BITS];
  assign d_pos    = !d_neg && (d_cur != '0);
  assign d_mag    = d_neg ? (~d_cur + 1'b1) : d_cur;
  assign mag_w    = {{(DW-CELL_BITS-1){1'b0}}, d_mag};
  assign cnt_w    = {{(DW-COUNT_BITS){1'b0}}, cnt_cur};
  assign lg_w     = {{(DW-LOGICAL_BITS){1'b0}}, lg[axis]};
  assign exp_axis = (d_pos && (mag_w <= cnt_w) && ((lg_w + mag_w) >= cnt_w)) ||
                    (d_neg && (lg_w < mag_w));

  // origin plus delta, taken apart into sign and magnitude for the modulo unit
  assign s_sum = {{(DW-COUNT_BITS){1'b0}}, ring_origin[axis]} +
                 {{(DW-CELL_BITS-1){d_cur[CELL_BITS]}}, d_cur};
  assign s_neg = s_sum[DW-1];
  assign s_mag = s_neg ? (~s_sum + 1'b1) : s_sum;
  assign q_sum = lg_w + {{(DW-COUNT_BITS){1'b0}}, ring_origin[axis]};

  assign mul_full = MW'(mul_a) * MW'(mul_b);

  always_comb begin
    state_next = state;
    case (state)
      SEQ_IDLE: begin
        if (accept) begin
          state_next = (func_t'(cmd.func) == FUNC_SCROLL) ? SEQ_DELTA : SEQ_START;
        end
      end
      SEQ_DELTA: begin
        if (plan_changed && !cnt_zero) begin
          state_next = SEQ_START;
        end else if (is_last) begin
          state_next = SEQ_DONE;
        end
      end
      SEQ_START: begin
        if (!cnt_zero) begin
          if (!mod_stat.busy) begin
            state_next = SEQ_WAIT;
          end
        end else if (is_last) begin
          state_next = SEQ_MUL_HI;
        end
      end
      SEQ_WAIT: begin
        if (mod_stat.done) begin
          if (is_last) begin
            state_next = is_scroll ? SEQ_DONE : SEQ_MUL_HI;
          end else begin
            state_next = is_scroll ? SEQ_DELTA : SEQ_START;
          end
        end
      end
      SEQ_MUL_HI:  state_next = SEQ_MUL_MID;
      SEQ_MUL_MID: state_next = SEQ_SUM;
      SEQ_SUM:     state_next = SEQ_DONE;
      SEQ_DONE: begin
        if (out_free) begin
          state_next = SEQ_IDLE;
        end
      end
      default: state_next = SEQ_IDLE;
    endcase
  end

  always_comb begin
    cmd.ready         = (state == SEQ_IDLE);
    mod_ctrl.start    = (state == SEQ_START) && !cnt_zero && !mod_stat.busy;
    mod_ctrl.short_op = !is_scroll;
    mod_ctrl.neg      = is_scroll && s_neg;
    mod_dividend      = is_scroll ? s_mag : q_sum;
    axis_adv          = 1'b0;
    mul_a             = INDEX_BITS'(phys[2]);
    mul_b             = counts[1];
    case (state)
      SEQ_DELTA:   axis_adv = !(plan_changed && !cnt_zero);
      SEQ_START:   axis_adv = cnt_zero;
      SEQ_WAIT:    axis_adv = mod_stat.done;
      SEQ_MUL_MID: begin
        mul_a = INDEX_BITS'(phys[1]) + prod;
        mul_b = counts[0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= SEQ_IDLE;
      axis              <= '0;
      plan_changed      <= 1'b0;
      plan_full_invalid <= 1'b0;
      rsp_valid         <= 1'b0;
      for (int a = 0; a < AXES; a++) begin
        ring_origin[a] <= '0;
        camera_cell[a] <= '0;
        cell_delta[a]  <= '0;
      end
    end else begin
      state <= state_next;
      if (axis_adv) begin
        axis <= is_last ? 2'd0 : axis + 2'd1;
      end
      case (state)
        SEQ_IDLE: begin
          if (accept) begin
            axis   <= '0;
            func_r <= func_t'(cmd.func);
            tgt[0] <= cmd.target_cell_x;
            tgt[1] <= cmd.target_cell_y;
            tgt[2] <= cmd.target_cell_z;
            lg[0]  <= cmd.logical_x;
            lg[1]  <= cmd.logical_y;
            lg[2]  <= cmd.logical_z;
            for (int a = 0; a < AXES; a++) begin
              phys[a] <= '0;
            end
            index_r <= '0;
            nexp    <= 1'b0;
            if (func_t'(cmd.func) == FUNC_SCROLL) begin
              plan_changed      <= changed_in;
              plan_full_invalid <= 1'b0;
            end
          end
        end
        SEQ_DELTA: begin
          cell_delta[axis]  <= d_new;
          camera_cell[axis] <= tgt[axis];
          if (plan_changed && cnt_zero) begin
            ring_origin[axis] <= '0;
            plan_full_invalid <= 1'b1;
          end
        end
        SEQ_START: begin
          if (is_scroll) begin
            if (mag_w >= cnt_w) begin
              plan_full_invalid <= 1'b1;
            end
          end else if (plan_changed) begin
            nexp <= nexp || plan_full_invalid || exp_axis;
          end
        end
        SEQ_WAIT: begin
          if (mod_stat.done) begin
            if (is_scroll) begin
              ring_origin[axis] <= mod_result;
            end else begin
              phys[axis] <= mod_result;
            end
          end
        end
        SEQ_MUL_HI, SEQ_MUL_MID: prod <= mul_full[INDEX_BITS-1:0];
        SEQ_SUM: index_r <= INDEX_BITS'(phys[0]) + prod;
        default: ;
      endcase
      rsp_valid <= (state == SEQ_DONE && out_free) || (rsp_valid && !rsp.ready);
    end
  end

  // response beat payload
  always_ff @(posedge clk) begin
    if (state == SEQ_DONE && out_free) begin
      for (int a = 0; a < AXES; a++) begin
        rsp_origin[a] <= ring_origin[a];
        rsp_phys[a]   <= phys[a];
      end
      rsp_moved <= plan_changed;
      rsp_full  <= plan_full_invalid;
      rsp_index <= index_r;
      rsp_nexp  <= nexp;
    end
  end

  assign rsp.valid         = rsp_valid;
  assign rsp.origin_x      = rsp_origin[0];
  assign rsp.origin_y      = rsp_origin[1];
  assign rsp.origin_z      = rsp_origin[2];
  assign rsp.moved         = rsp_moved;
  assign rsp.full_invalid  = rsp_full;
  assign rsp.phys_x        = rsp_phys[0];
  assign rsp.phys_y        = rsp_phys[1];
  assign rsp.phys_z        = rsp_phys[2];
  assign rsp.phys_index    = rsp_index;
  assign rsp.newly_exposed = rsp_nexp;

endmodule

// ----- hdl/tpgs_regs.sv -----
// ----------------------------------------------------------------------------
// tpgs_regs
// APB register file holding the per-axis probe counts.
// ----------------------------------------------------------------------------
module tpgs_regs
  import tpgs_pkg::*;
#(
  parameter int COUNT_BITS = 8
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [APB_ADDR_BITS-1:0]             paddr,
  input  logic [APB_DATA_BITS-1:0]             pwdata,
  output logic [APB_DATA_BITS-1:0]             prdata,
  output logic                                 pready,
  output logic [AXES-1:0][COUNT_BITS-1:0]      counts
);

  reg_index_t idx;
  logic       wr_en;

  assign idx    = reg_index_t'(paddr[APB_ADDR_BITS-1:2]);
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int a = 0; a < AXES; a++) begin
        counts[a] <= COUNT_BITS'(RESET_COUNT);
      end
    end else if (wr_en) begin
      case (idx)
        REG_COUNT_X: counts[0] <= pwdata[COUNT_BITS-1:0];
        REG_COUNT_Y: counts[1] <= pwdata[COUNT_BITS-1:0];
        REG_COUNT_Z: counts[2] <= pwdata[COUNT_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_COUNT_X: prdata = APB_DATA_BITS'(counts[0]);
      REG_COUNT_Y: prdata = APB_DATA_BITS'(counts[1]);
      REG_COUNT_Z: prdata = APB_DATA_BITS'(counts[2]);
      default:     prdata = '0;
    endcase
  end

endmodule

// ----- hdl/tpgs_mod.sv -----
// ----------------------------------------------------------------------------
// tpgs_mod
// Bit-serial restoring modulo unit with floor correction for negative values.
// ----------------------------------------------------------------------------
module tpgs_mod
  import tpgs_pkg::*;
#(
  parameter int COUNT_BITS = 8,
  parameter int DW         = 26,
  parameter int QW         = 9
) (
  input  logic                  clk,
  input  logic                  rst,
  input  mod_ctrl_t             ctrl,
  input  logic [DW-1:0]         dividend,
  input  logic [COUNT_BITS-1:0] modulus,
  output logic [COUNT_BITS-1:0] result,
  output mod_stat_t             stat
);

  localparam int CW = $clog2(DW + 1);

  mod_state_t            state;
  mod_state_t            state_next;
  logic [DW-1:0]         dvd;
  logic [COUNT_BITS-1:0] rem;
  logic [CW-1:0]         cnt;
  logic                  neg_r;
  logic [COUNT_BITS:0]   rem_sh;
  logic [COUNT_BITS:0]   n_ext;
  logic [COUNT_BITS-1:0] rem_step;

  assign rem_sh   = {rem, dvd[DW-1]};
  assign n_ext    = {1'b0, modulus};
  assign rem_step = (rem_sh >= n_ext) ? COUNT_BITS'(rem_sh - n_ext)
                                      : rem_sh[COUNT_BITS-1:0];

  always_comb begin
    case (state)
      MOD_IDLE: state_next = ctrl.start ? MOD_RUN : MOD_IDLE;
      MOD_RUN:  state_next = (cnt == CW'(1)) ? MOD_FIX : MOD_RUN;
      MOD_FIX:  state_next = MOD_IDLE;
      default:  state_next = MOD_IDLE;
    endcase
  end

  always_comb begin
    stat.busy = (state != MOD_IDLE);
    stat.done = (state == MOD_FIX);
    result    = (neg_r && rem != '0) ? (modulus - rem) : rem;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= MOD_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      MOD_IDLE: begin
        if (ctrl.start) begin
          rem   <= '0;
          neg_r <= ctrl.neg;
          if (ctrl.short_op) begin
            dvd <= dividend << (DW - QW);
            cnt <= CW'(QW);
          end else begin
            dvd <= dividend;
            cnt <= CW'(DW);
          end
        end
      end
      MOD_RUN: begin
        rem <= rem_step;
        dvd <= dvd << 1;
        cnt <= cnt - CW'(1);
      end
      default: ;
    endcase
  end

endmodule

// ----- hdl/tpgs_checker.sv -----
// ----------------------------------------------------------------------------
// tpgs_checker
// Port-level checks on the scroller's command and response channels.
// ----------------------------------------------------------------------------
module tpgs_port_checks (
  input logic clk,
  input logic rst,
  input logic cmd_valid,
  input logic cmd_ready,
  input logic rsp_valid,
  input logic rsp_ready,
  input logic rsp_moved,
  input logic rsp_full_invalid,
  input logic rsp_newly_exposed
);

  // a stalled response beat stays up
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("response beat dropped while stalled");

  // one item at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready |=> !cmd_ready)
    else $error("command taken while busy");

  a_full_needs_move: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_full_invalid |-> rsp_moved)
    else $error("full invalidation without a move");

  a_exposed_needs_move: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_newly_exposed |-> rsp_moved)
    else $error("exposed probe without a move");

endmodule

bind toroidal_probe_grid_scroller_core tpgs_port_checks u_checker (
  .clk              (clk),
  .rst              (rst),
  .cmd_valid        (cmd.valid),
  .cmd_ready        (cmd.ready),
  .rsp_valid        (rsp.valid),
  .rsp_ready        (rsp.ready),
  .rsp_moved        (rsp.moved),
  .rsp_full_invalid (rsp.full_invalid),
  .rsp_newly_exposed(rsp.newly_exposed)
);
